FILE: hw/rtl/bsl_pkg.sv
// Shared types and constants for the bounded sequential list.
package bsl_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int RECORD_WIDTH_DEF = 64;
  localparam int DATA_W = 64;

  localparam logic [1:0] KIND_APPEND = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_SWAP   = 2'd2;
  localparam logic [1:0] KIND_READ   = 2'd3;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // Per-cycle command to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic append;
    logic rotate;
  } cell_ctl_t;

endpackage

FILE: hw/rtl/bsl_cell.sv
// One storage cell of the list chain: holds the record at list index IDX.
module bsl_cell #(
  parameter int IDX = 0,
  parameter int RECORD_WIDTH = bsl_pkg::RECORD_WIDTH_DEF,
  parameter int CNT_W = 7
) (
  input  logic                    clk,
  input  bsl_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic [RECORD_WIDTH-1:0] wr_data,
  input  logic [RECORD_WIDTH-1:0] prev_data,
  input  logic [RECORD_WIDTH-1:0] next_data,
  input  logic [RECORD_WIDTH-1:0] feed,
  output logic [RECORD_WIDTH-1:0] q
);

  logic is_tail;
  logic is_free;
  logic is_used;

  assign is_free = (count == CNT_W'(IDX));
  assign is_tail = (count == CNT_W'(IDX + 1));
  assign is_used = (CNT_W'(IDX) < count);

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      q <= prev_data;
    end else if (ctl.append && is_free) begin
      q <= wr_data;
    end else if (ctl.rotate && is_used) begin
      // ring closes at the last held record
      q <= is_tail ? feed : next_data;
    end
  end

endmodule

FILE: hw/rtl/bsl_chain.sv
// Row of list cells; shifts back on insert, rotates toward the head on scans.
module bsl_chain #(
  parameter int DEPTH = bsl_pkg::DEPTH_DEF,
  parameter int RECORD_WIDTH = bsl_pkg::RECORD_WIDTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                    clk,
  input  bsl_pkg::cell_ctl_t      ctl,
  input  logic [CNT_W-1:0]        count,
  input  logic [RECORD_WIDTH-1:0] wr_data,
  input  logic [RECORD_WIDTH-1:0] feed,
  output logic [RECORD_WIDTH-1:0] head
);

  logic [RECORD_WIDTH-1:0] cell_q [DEPTH];

  assign head = cell_q[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [RECORD_WIDTH-1:0] prev_data;
    logic [RECORD_WIDTH-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = wr_data;
    end else begin : g_prev
      assign prev_data = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = feed;
    end else begin : g_next
      assign next_data = cell_q[i+1];
    end

    bsl_cell #(
      .IDX(i),
      .RECORD_WIDTH(RECORD_WIDTH),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk(clk),
      .ctl(ctl),
      .count(count),
      .wr_data(wr_data),
      .prev_data(prev_data),
      .next_data(next_data),
      .feed(feed),
      .q(cell_q[i])
    );
  end

endmodule

FILE: hw/rtl/bounded_sequential_list_unit.sv
// Top level of the bounded sequential list: command decode, scan sequencer, result.
//
// Usage: drive kind, pos_a, pos_b and entry_data with start high; the item is
// taken at the rising edge where start is high and busy is low. Each item
// gives one result (status, read_data, entry_count) on the result ports for
// exactly one cycle, marked by done. The receiver cannot stall; results are
// never held back.
// Timing: for append, insert and any refused command, done
// shows in the cycle after acceptance and busy never rises, so a new item
// may be taken every cycle. A read rotates the held records once around the
// cell ring and then shows done; a swap makes a capture pass and a
// write-back pass and then shows done. Each pass is as long as the ring,
// i.e. the number of held records. busy is low again in the cycle where
// done shows.
// Reset: rst (synchronous, active high) empties the list; record storage is
// not cleared and needs no clearing pass.
module bounded_sequential_list_unit #(
  parameter int DEPTH = bsl_pkg::DEPTH_DEF,
  parameter int RECORD_WIDTH = bsl_pkg::RECORD_WIDTH_DEF,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                kind,
  input  logic [CNT_W-1:0]          pos_a,
  input  logic [CNT_W-1:0]          pos_b,
  input  logic [bsl_pkg::DATA_W-1:0] entry_data,
  output logic                      done,
  output logic                      status,
  output logic [bsl_pkg::DATA_W-1:0] read_data,
  output logic [CNT_W-1:0]          entry_count
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_WRITE = 2'd2;

  logic [1:0]              state;
  logic [1:0]              state_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W-1:0]        step;
  logic [CNT_W-1:0]        step_next;
  logic [CNT_W-1:0]        pa;
  logic [CNT_W-1:0]        pb;
  logic                    is_swap;
  logic [RECORD_WIDTH-1:0] hold_a;
  logic [RECORD_WIDTH-1:0] hold_b;
  logic                    done_next;
  logic                    status_next;
  logic [bsl_pkg::DATA_W-1:0] read_data_next;

  bsl_pkg::cell_ctl_t      ctl;
  logic [RECORD_WIDTH-1:0] head;
  logic [RECORD_WIDTH-1:0] feed;
  logic [RECORD_WIDTH-1:0] wr_data;
  logic [CNT_W-1:0]        step_pos;
  logic                    accept;
  logic                    full;
  logic                    a_ok;
  logic                    b_ok;
  logic                    last_step;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(DEPTH));
  assign a_ok      = (pos_a != '0) && (pos_a <= count);
  assign b_ok      = (pos_b != '0) && (pos_b <= count);
  assign wr_data   = entry_data[RECORD_WIDTH-1:0];
  assign step_pos  = step + CNT_W'(1);
  assign last_step = (step_pos == count);

  // head of the ring holds list position step_pos during a pass
  always_comb begin
    feed = head;
    if (state == ST_WRITE) begin
      if (step_pos == pa) begin
        feed = hold_b;
      end else if (step_pos == pb) begin
        feed = hold_a;
      end
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    step_next      = step;
    done_next      = 1'b0;
    status_next    = status;
    read_data_next = read_data;
    ctl            = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          done_next      = 1'b1;
          status_next    = bsl_pkg::STATUS_REFUSED;
          read_data_next = '0;
          step_next      = '0;
          unique case (kind) inside
            bsl_pkg::KIND_APPEND, bsl_pkg::KIND_INSERT: begin
              if (!full) begin
                ctl.append  = (kind == bsl_pkg::KIND_APPEND);
                ctl.insert  = (kind == bsl_pkg::KIND_INSERT);
                count_next  = count + CNT_W'(1);
                status_next = bsl_pkg::STATUS_DONE;
              end
            end
            bsl_pkg::KIND_SWAP: begin
              if (a_ok && b_ok) begin
                done_next  = 1'b0;
                state_next = ST_SCAN;
              end
            end
            bsl_pkg::KIND_READ: begin
              if (a_ok) begin
                done_next  = 1'b0;
                state_next = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ctl.rotate = 1'b1;
        step_next  = step_pos;
        if (last_step) begin
          step_next = '0;
          if (is_swap) begin
            state_next = ST_WRITE;
          end else begin
            state_next     = ST_IDLE;
            done_next      = 1'b1;
            status_next    = bsl_pkg::STATUS_DONE;
            read_data_next = bsl_pkg::DATA_W'((step_pos == pa) ? head : hold_a);
          end
        end
      end
      ST_WRITE: begin
        ctl.rotate = 1'b1;
        step_next  = step_pos;
        if (last_step) begin
          step_next      = '0;
          state_next     = ST_IDLE;
          done_next      = 1'b1;
          status_next    = bsl_pkg::STATUS_DONE;
          read_data_next = '0;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    status      <= status_next;
    read_data   <= read_data_next;
    entry_count <= count_next;
    if (accept) begin
      pa      <= pos_a;
      pb      <= pos_b;
      is_swap <= (kind == bsl_pkg::KIND_SWAP);
    end
    if (state == ST_SCAN) begin
      if (step_pos == pa) begin
        hold_a <= head;
      end
      if (step_pos == pb) begin
        hold_b <= head;
      end
    end
  end

  bsl_chain #(
    .DEPTH(DEPTH),
    .RECORD_WIDTH(RECORD_WIDTH),
    .CNT_W(CNT_W)
  ) u_chain (
    .clk(clk),
    .ctl(ctl),
    .count(count),
    .wr_data(wr_data),
    .feed(feed),
    .head(head)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("record count above depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> $stable(count))
    else $error("record count changed during a pass");

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step < count))
    else $error("pass step beyond held records");

  a_no_done_busy: assert property (@(posedge clk) disable iff (rst)
    (busy && !last_step) |=> !done)
    else $error("result strobe in the middle of a pass");

endmodule
